// File: src/rtsfe_pkg.sv
package rtsfe_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hA7;
    localparam logic [7:0] LIFT_EXT_BYTE = 8'hC4;
    localparam logic [7:0] STEP_EXT_BYTE = 8'h84;
    localparam logic [7:0] LIFT_UP_B8    = 8'h20;
    localparam logic [7:0] LIFT_DN_B8    = 8'h2C;
    localparam logic [7:0] LIFT_OTH_B8   = 8'h00;
    localparam logic [3:0] LIFT_UP_B9HI  = 4'h0;
    localparam logic [3:0] LIFT_DN_B9HI  = 4'h8;
    localparam logic [3:0] LIFT_OTH_B9HI = 4'h1;
    localparam logic [3:0] STEP_B8HI     = 4'h3;
    localparam logic [6:0] STEP_MIN      = 7'd1;
    localparam logic [6:0] STEP_MAX      = 7'h7F;

    localparam int FRAME_BYTES = 10;
    localparam logic [3:0] SHORT_LAST = 4'd6;
    localparam logic [3:0] LONG_LAST  = 4'd9;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef enum logic [CFG_AW-1:0] {
        REG_REMOTE_ADDR = 3'd0,
        REG_LONG_FRAMES = 3'd1,
        REG_UP_BUTTON   = 3'd2,
        REG_DOWN_BUTTON = 3'd3,
        REG_STEP_BUTTON = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] remote_address;
        logic        long_frames;
        logic [3:0]  up_button;
        logic [3:0]  down_button;
        logic [3:0]  step_button;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [3:0]                  last_idx;
    } t_frame;

endpackage

// File: src/rtsfe_build.sv
module rtsfe_build
    import rtsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic [3:0]  i_button,
    input  logic [15:0] i_rolling_code,
    input  logic [7:0]  i_step_count,
    input  logic        i_step_up,
    output logic        o_valid,
    output t_frame      o_frame,
    input  logic        i_ready
);

    // stage 1: captured request
    logic        r_s1_valid;
    logic        r_s1_cmd;
    logic [3:0]  r_s1_button;
    logic [15:0] r_s1_code;
    logic [7:0]  r_s1_steps;
    logic        r_s1_up;

    // stage 2: raw base bytes, checksum, extension bytes
    logic                  r_s2_valid;
    logic [6:0][7:0]       r_s2_base;
    logic [7:0]            r_s2_e7;
    logic [7:0]            r_s2_e8;
    logic [3:0]            r_s2_e9hi;
    logic [3:0]            r_s2_last;

    // stage 3: finished frame
    logic   r_s3_valid;
    t_frame r_s3_frame;

    logic s3_adv, s2_free, s1_free;

    assign s3_adv  = r_s3_valid && i_ready;
    assign s2_free = !r_s2_valid || !r_s3_valid || s3_adv;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_busy  = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            // zero rolling code: nothing to send
            r_s1_valid <= i_start && (i_rolling_code != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_cmd    <= i_cmd;
            r_s1_button <= i_button;
            r_s1_code   <= i_rolling_code;
            r_s1_steps  <= i_step_count;
            r_s1_up     <= i_step_up;
        end
    end

    logic [3:0] s2_btn;
    logic [6:0] s2_steps;
    logic [3:0] s2_ck;
    logic [6:0][7:0] n_s2_base;
    logic [7:0] n_s2_e7, n_s2_e8;
    logic [3:0] n_s2_e9hi;

    always_comb begin
        s2_btn = r_s1_cmd ? i_cfg.step_button : r_s1_button;
        if (r_s1_steps == 8'd0) begin
            s2_steps = STEP_MIN;
        end else if (r_s1_steps[7]) begin
            s2_steps = STEP_MAX;
        end else begin
            s2_steps = r_s1_steps[6:0];
        end
        s2_ck = SYNC_BYTE[7:4] ^ SYNC_BYTE[3:0] ^ s2_btn
              ^ r_s1_code[15:12] ^ r_s1_code[11:8] ^ r_s1_code[7:4] ^ r_s1_code[3:0]
              ^ i_cfg.remote_address[23:20] ^ i_cfg.remote_address[19:16]
              ^ i_cfg.remote_address[15:12] ^ i_cfg.remote_address[11:8]
              ^ i_cfg.remote_address[7:4]   ^ i_cfg.remote_address[3:0];
        n_s2_base[0] = SYNC_BYTE;
        n_s2_base[1] = {s2_btn, s2_ck};
        n_s2_base[2] = r_s1_code[15:8];
        n_s2_base[3] = r_s1_code[7:0];
        n_s2_base[4] = i_cfg.remote_address[23:16];
        n_s2_base[5] = i_cfg.remote_address[15:8];
        n_s2_base[6] = i_cfg.remote_address[7:0];
        if (r_s1_cmd) begin
            n_s2_e7   = STEP_EXT_BYTE;
            n_s2_e8   = {STEP_B8HI, r_s1_up, s2_steps[6:4]};
            n_s2_e9hi = s2_steps[3:0];
        end else begin
            n_s2_e7 = LIFT_EXT_BYTE;
            // up wins when up and down codes match
            if (r_s1_button == i_cfg.up_button) begin
                n_s2_e8   = LIFT_UP_B8;
                n_s2_e9hi = LIFT_UP_B9HI;
            end else if (r_s1_button == i_cfg.down_button) begin
                n_s2_e8   = LIFT_DN_B8;
                n_s2_e9hi = LIFT_DN_B9HI;
            end else begin
                n_s2_e8   = LIFT_OTH_B8;
                n_s2_e9hi = LIFT_OTH_B9HI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_base  <= n_s2_base;
            r_s2_e7    <= n_s2_e7;
            r_s2_e8    <= n_s2_e8;
            r_s2_e9hi  <= n_s2_e9hi;
            r_s2_last  <= (r_s1_cmd || i_cfg.long_frames) ? LONG_LAST : SHORT_LAST;
        end
    end

    t_frame     n_s3_frame;
    logic [3:0] s3_ext_ck;

    always_comb begin
        n_s3_frame.bytes[0] = r_s2_base[0];
        for (int i = 1; i < 7; i++) begin
            n_s3_frame.bytes[i] = r_s2_base[i] ^ n_s3_frame.bytes[i-1];
        end
        s3_ext_ck = r_s2_e7[7:4] ^ r_s2_e7[3:0] ^ r_s2_e8[7:4] ^ r_s2_e8[3:0] ^ r_s2_e9hi;
        n_s3_frame.bytes[7] = r_s2_e7;
        n_s3_frame.bytes[8] = r_s2_e8;
        n_s3_frame.bytes[9] = {r_s2_e9hi, s3_ext_ck};
        n_s3_frame.last_idx = r_s2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (!r_s3_valid || s3_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_s3_valid || s3_adv) begin
            r_s3_frame <= n_s3_frame;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_frame = r_s3_frame;

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && !i_ready |=> r_s3_valid && $stable(r_s3_frame))
        else $error("stalled frame changed");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !s2_free |=> r_s2_valid && $stable(r_s2_base))
        else $error("stage 2 lost its item");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> r_s1_valid && $stable(r_s1_code))
        else $error("stage 1 changed while busy");

endmodule

// File: src/rtsfe_serial.sv
module rtsfe_serial
    import rtsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_frame     i_frame,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_frame_byte,
    output logic [3:0] o_byte_index,
    output logic       o_last
);

    logic                        r_active;
    logic [3:0]                  r_idx;
    logic [3:0]                  r_last_idx;
    logic [FRAME_BYTES-1:0][7:0] r_shift;

    logic at_end, load;

    assign at_end  = (r_idx == r_last_idx);
    assign o_ready = !r_active || at_end;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 4'd0;
        end else if (load) begin
            r_active <= 1'b1;
            r_idx    <= 4'd0;
        end else if (r_active) begin
            r_active <= !at_end;
            r_idx    <= r_idx + 4'd1;
        end
    end

    // the byte being sent always sits at the bottom of the shift line; a load puts byte 0 there
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_shift    <= i_frame.bytes;
            r_last_idx <= i_frame.last_idx;
        end else if (r_active) begin
            r_shift <= {8'h00, r_shift[FRAME_BYTES-1:1]};
        end
    end

    assign o_valid      = r_active;
    assign o_frame_byte = r_shift[0];
    assign o_byte_index = r_idx;
    assign o_last       = r_active && at_end;

    a_first_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_index == 4'd0 |-> o_frame_byte == SYNC_BYTE)
        else $error("frame does not open with sync byte");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && !at_end |=> r_active && r_idx == $past(r_idx) + 4'd1)
        else $error("byte index skipped");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_last_idx == SHORT_LAST || r_last_idx == LONG_LAST)
        else $error("bad frame length");

endmodule

// File: src/rts_rolling_code_frame_encoder_top.sv
// Rolling-code remote frame encoder. Hold start high with a request until an edge where
// busy is low takes it; the block answers with the frame one byte per cycle on
// o_frame_byte, each byte marked by o_valid for exactly one cycle, o_byte_index giving
// its position and o_last flagging the final byte. Frames are 7 bytes (lift, short) or
// 10 bytes (lift with long frames enabled, all step frames); a zero rolling code produces
// no bytes. The receiver cannot stall: every strobed byte must be taken. An accepted
// request passes the three build stages into the byte serializer, which takes the
// next frame while sending the current one's last byte, so the one-byte-per-cycle
// output sets the sustained rate. Requests queue in the three build stages; busy rises
// only when they are all full. The user must write configuration registers through
// i_cfg_we/i_cfg_addr/i_cfg_wdata only while no frame is in flight; nothing enforces it.
module rts_rolling_code_frame_encoder_top
    import rtsfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [3:0]        i_button,
    input  logic [15:0]       i_rolling_code,
    input  logic [7:0]        i_step_count,
    input  logic              i_step_up,
    output logic              o_valid,
    output logic [7:0]        o_frame_byte,
    output logic [3:0]        o_byte_index,
    output logic              o_last
);

    t_cfg   r_cfg;
    logic   bld_valid;
    t_frame bld_frame;
    logic   ser_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.remote_address <= 24'd0;
            r_cfg.long_frames    <= 1'b0;
            r_cfg.up_button      <= 4'd2;
            r_cfg.down_button    <= 4'd4;
            r_cfg.step_button    <= 4'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                REG_REMOTE_ADDR: r_cfg.remote_address <= i_cfg_wdata;
                REG_LONG_FRAMES: r_cfg.long_frames    <= i_cfg_wdata[0];
                REG_UP_BUTTON:   r_cfg.up_button      <= i_cfg_wdata[3:0];
                REG_DOWN_BUTTON: r_cfg.down_button    <= i_cfg_wdata[3:0];
                REG_STEP_BUTTON: r_cfg.step_button    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    rtsfe_build u_build (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (start),
        .o_busy         (busy),
        .i_cmd          (i_cmd),
        .i_button       (i_button),
        .i_rolling_code (i_rolling_code),
        .i_step_count   (i_step_count),
        .i_step_up      (i_step_up),
        .o_valid        (bld_valid),
        .o_frame        (bld_frame),
        .i_ready        (ser_ready)
    );

    rtsfe_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (bld_valid),
        .i_frame      (bld_frame),
        .o_ready      (ser_ready),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule
